/* hdl/srect_pkg.sv */
// Shared types and helpers for the segment/rectangle intersection core.
// No dependencies; used by srect_ratio_chk and segment_rect_intersect_core.
package srect_pkg;

  // Stream payload widths.
  localparam int unsigned InDataW  = 256;
  localparam int unsigned OutDataW = 8;

  // Coordinate differences, products and cross-product differences.
  typedef logic signed [32:0] diff_t;
  typedef logic signed [33:0] diff_wide_t;
  typedef logic signed [64:0] den_t;
  typedef logic signed [66:0] prod_t;
  typedef logic signed [67:0] cross_t;

  // Per-edge flags, one bit for each of top, left, bottom and right.
  typedef struct packed {
    logic top;
    logic left;
    logic bottom;
    logic right;
  } edge_flags_t;

  // True when num/den lies in [0,1]; den is assumed nonzero by the caller.
  function automatic logic in_unit_n(input diff_wide_t num, input diff_wide_t den);
    logic res;
    if (!den[33]) begin
      res = (num >= 0) && (num <= den);
    end else begin
      res = (num <= 0) && (num >= den);
    end
    return res;
  endfunction

endpackage

/* hdl/segment_rect_intersect_core.sv */
// Segment against axis-aligned rectangle intersection test, four-stage pipeline.
// Depends on srect_pkg and srect_ratio_chk.
//
// Each input beat carries a segment (start and end point) and a rectangle
// (corner, width, height) in signed fixed point; the output beat carries a
// single hit bit, set when the segment meets any of the four rectangle edges,
// touching endpoints included and parallel edges ignored. The scale of the
// fixed-point format cancels, so any number of fraction bits gives the same
// answer. The core accepts one beat in every clock cycle unless output
// backpressure has filled the pipeline. One stage forms coordinate differences,
// one the six signed products (the widest about 34 by 33 bits), one the cross
// product differences and one the range compares into the output register.
// Results leave in input order; backpressure on the output stalls only as
// far back as needed, so bubbles in the pipeline still take new beats.
module segment_rect_intersect_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0 up: seg_start_x[31:0], seg_start_y[63:32],
  // seg_end_x[95:64], seg_end_y[127:96], rect_x[159:128], rect_y[191:160],
  // rect_width[222:192], rect_height[253:223], zero padding [255:254].
  input  logic [srect_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0 up: hit[0], zero padding [7:1].
  output logic [srect_pkg::OutDataW-1:0] m_axis_tdata
);
  import srect_pkg::*;

  // Input field unpacking.
  logic signed [31:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  logic signed [31:0] rect_x, rect_y;
  logic        [30:0] rect_width, rect_height;

  assign seg_start_x = s_axis_tdata[31:0];
  assign seg_start_y = s_axis_tdata[63:32];
  assign seg_end_x   = s_axis_tdata[95:64];
  assign seg_end_y   = s_axis_tdata[127:96];
  assign rect_x      = s_axis_tdata[159:128];
  assign rect_y      = s_axis_tdata[191:160];
  assign rect_width  = s_axis_tdata[222:192];
  assign rect_height = s_axis_tdata[253:223];

  // Stage valids and the per-stage ready chain.
  logic v1, v2, v3, out_valid;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out       = !out_valid || m_axis_tready;
  assign rdy3          = !v3 || rdy_out;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  // Stage 1: direction vector and offsets from the segment start.
  diff_t      s1_rx, s1_ry, s1_nry, s1_dx, s1_dy;
  diff_wide_t s1_dxr, s1_dyb;
  logic [30:0] s1_w, s1_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_axis_tvalid) begin
      s1_rx  <= 33'(seg_end_x) - 33'(seg_start_x);
      s1_ry  <= 33'(seg_end_y) - 33'(seg_start_y);
      s1_nry <= 33'(seg_start_y) - 33'(seg_end_y);
      s1_dx  <= 33'(rect_x) - 33'(seg_start_x);
      s1_dy  <= 33'(rect_y) - 33'(seg_start_y);
      s1_dxr <= 34'(rect_x) + $signed({3'b000, rect_width}) - 34'(seg_start_x);
      s1_dyb <= 34'(rect_y) + $signed({3'b000, rect_height}) - 34'(seg_start_y);
      s1_w   <= rect_width;
      s1_h   <= rect_height;
    end
  end

  // Stage 2: products and the narrow parameter tests along the segment.
  logic signed [31:0] w_s, h_s;
  den_t        s2_dw, s2_dh;
  prod_t       s2_ma, s2_mb, s2_mc, s2_md;
  edge_flags_t s2_t, t_next;

  assign w_s = $signed({1'b0, s1_w});
  assign h_s = $signed({1'b0, s1_h});

  always_comb begin
    t_next.top    = (s1_ry != 0) && (s1_w != 0) && in_unit_n(34'(s1_dy), 34'(s1_ry));
    t_next.left   = (s1_rx != 0) && (s1_h != 0) && in_unit_n(34'(s1_dx), 34'(s1_rx));
    t_next.bottom = (s1_ry != 0) && (s1_w != 0) && in_unit_n(s1_dyb, 34'(s1_ry));
    t_next.right  = (s1_rx != 0) && (s1_h != 0) && in_unit_n(s1_dxr, 34'(s1_rx));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_dw <= s1_nry * w_s;
      s2_dh <= s1_rx * h_s;
      s2_ma <= s1_dx * s1_ry;
      s2_mb <= s1_dy * s1_rx;
      s2_mc <= s1_dyb * s1_rx;
      s2_md <= s1_dxr * s1_ry;
      s2_t  <= t_next;
    end
  end

  // Stage 3: cross products of the offsets with the segment direction.
  den_t        s3_dw, s3_dh;
  cross_t      s3_c1, s3_c3, s3_c4;
  edge_flags_t s3_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3_c1 <= 68'(s2_ma) - 68'(s2_mb);
      s3_c3 <= 68'(s2_ma) - 68'(s2_mc);
      s3_c4 <= 68'(s2_md) - 68'(s2_mb);
      s3_dw <= s2_dw;
      s3_dh <= s2_dh;
      s3_t  <= s2_t;
    end
  end

  // Stage 4: parameter tests along each edge, combined into the hit bit.
  edge_flags_t u_ok;
  logic        hit_next, hit_q;

  srect_ratio_chk u_top    (.num(s3_c1), .den(68'(s3_dw)), .in_range(u_ok.top));
  srect_ratio_chk u_left   (.num(s3_c1), .den(68'(s3_dh)), .in_range(u_ok.left));
  srect_ratio_chk u_bottom (.num(s3_c3), .den(68'(s3_dw)), .in_range(u_ok.bottom));
  srect_ratio_chk u_right  (.num(s3_c4), .den(68'(s3_dh)), .in_range(u_ok.right));

  assign hit_next = (s3_t.top && u_ok.top) || (s3_t.left && u_ok.left) ||
                    (s3_t.bottom && u_ok.bottom) || (s3_t.right && u_ok.right);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_out) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v3) begin
      hit_q <= hit_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutDataW-1){1'b0}}, hit_q};

`ifndef SYNTHESIS
  // An empty output register means nothing can hold the input back.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("input not ready while output stage is empty");

  // A stalled first stage keeps its beat.
  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> (v1 && $stable(s1_rx) && $stable(s1_dxr)))
    else $error("stage 1 beat lost or changed under stall");

  // A degenerate rectangle with no extent on either axis never reports a hit.
  a_no_hit_degenerate: assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy_out && s3_dw == 0 && s3_dh == 0) |=> !hit_q)
    else $error("hit reported with zero denominators on every edge");
`endif

endmodule

/* hdl/srect_ratio_chk.sv */
// Wide ratio range check: tells whether num/den lies in [0,1] without dividing.
// Depends on srect_pkg for the cross-product type.
module srect_ratio_chk (
  input  srect_pkg::cross_t num,
  input  srect_pkg::cross_t den,
  output logic              in_range
);
  import srect_pkg::*;

  // The sign of the denominator decides which way the two bounds face.
  always_comb begin
    if (!den[67]) begin
      in_range = (num >= 0) && (num <= den);
    end else begin
      in_range = (num <= 0) && (num >= den);
    end
  end

endmodule
